@@ hdl/sorted_list_intersection_unit_macros.svh @@
// Assertion macros used by the design file that checks its own logic.
`ifndef SORTED_LIST_INTERSECTION_UNIT_MACROS_SVH
`define SORTED_LIST_INTERSECTION_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLI_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sli assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SLI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sli assertion failed");

`endif

@@ hdl/sli_pkg.sv @@
`timescale 1ns / 1ps
package sli_pkg;

  localparam int VAL_W = 32;
  localparam int SEL_W = 3;
  localparam int OP_W  = 2;
  localparam int STA_W = 2;
  localparam int CFG_W = 4;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd2;
  localparam int               MIN_LISTS = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_RUN    = 2'd2
  } op_t;

  typedef enum logic [STA_W-1:0] {
    STAT_MATCH = 2'd0,
    STAT_OK    = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_NONE  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_KEY_RD,
    S_KEY_WT,
    S_SRCH_INIT,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_MATCH,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic clr;
    logic inc;
  } len_cmd_t;

endpackage

@@ hdl/sli_in_if.sv @@
`timescale 1ns / 1ps
interface sli_in_if import sli_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [SEL_W-1:0] list_select;
  logic [VAL_W-1:0] element_value;

  modport source(output valid, operation, list_select, element_value, input ready);
  modport sink(input valid, operation, list_select, element_value, output ready);
endinterface

@@ hdl/sli_out_if.sv @@
`timescale 1ns / 1ps
interface sli_out_if import sli_pkg::*;;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] match_value;
  logic [STA_W-1:0] status;
  logic             last;

  modport source(output valid, match_value, status, last, input ready);
  modport sink(input valid, match_value, status, last, output ready);
endinterface

@@ hdl/sli_mem.sv @@
`timescale 1ns / 1ps
module sli_mem #(
  parameter int AW = 9,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/sli_len.sv @@
`timescale 1ns / 1ps
module sli_len import sli_pkg::*; #(
  parameter int NL = 8,
  parameter int LW = 3,
  parameter int CW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  len_cmd_t      cmd,
  input  logic [LW-1:0] inc_idx,
  input  logic [LW-1:0] rd_idx,
  output logic [CW-1:0] rd_len
);
  logic [CW-1:0] len_r [NL];

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      for (int k = 0; k < NL; k++) begin
        len_r[k] <= '0;
      end
    end else if (cmd.inc) begin
      len_r[inc_idx] <= len_r[inc_idx] + CW'(1);
    end
  end

  assign rd_len = (32'(rd_idx) < NL) ? len_r[rd_idx] : '0;
endmodule

@@ hdl/sorted_list_intersection_unit.sv @@
`timescale 1ns / 1ps
// Clear and append: the result word is valid in the cycle after the item is taken,
// and such items can follow one per cycle while the output is free.
// Run: each element of list 0 is fetched via a read and a wait state; per list searched, a
// setup state, then a read and a compare state per probe (at most ceil(log2(length+1)) probes);
// a miss ends the search in the read state. A stalled output can hold the match or finish state.
// Reset empties every list and sets list_count to 2; stored values are not cleared.
`include "sorted_list_intersection_unit_macros.svh"
module sorted_list_intersection_unit import sli_pkg::*; #(
  parameter int MAX_LISTS  = 8,
  parameter int LIST_DEPTH = 64
) (
  input logic             clk,
  input logic             rst_n,
  sli_in_if.sink          in_ch,
  sli_out_if.source       out_ch,
  input logic             cfg_we,
  input logic [CFG_W-1:0] cfg_wdata
);
  localparam int LW = $clog2(MAX_LISTS);
  localparam int PW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int AW = LW + PW;
  localparam int NW = LW + 1;

  state_t           state_r, state_nxt;
  logic [CFG_W-1:0] cfg_r;
  logic [NW-1:0]    n_eff;
  logic [CW-1:0]    i_r, i_nxt;
  logic [LW-1:0]    j_r, j_nxt;
  logic [NW-1:0]    j_inc;
  logic [CW-1:0]    lo_r, lo_nxt, hi_x_r, hi_x_nxt, mid_r, mid_nxt;
  logic [CW-1:0]    diff;
  logic [VAL_W-1:0] key_r, key_nxt, pend_r, pend_nxt;
  logic             pend_valid_r, pend_valid_nxt;

  logic             out_valid_r, out_last_r, out_last_nxt, out_load;
  logic [VAL_W-1:0] out_value_r, out_value_nxt;
  status_t          out_status_r, out_status_nxt;
  logic             slot_free;

  len_cmd_t         len_cmd;
  logic [LW-1:0]    len_idx, sel_idx;
  logic [CW-1:0]    len_q;
  logic             sel_ok, list_full;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [VAL_W-1:0] mem_rdata;

  logic             run_taken, none_shown;

  sli_mem #(.AW(AW), .DW(VAL_W)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_ch.element_value),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sli_len #(.NL(MAX_LISTS), .LW(LW), .CW(CW)) u_len (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (len_cmd),
    .inc_idx (sel_idx),
    .rd_idx  (len_idx),
    .rd_len  (len_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (32'(cfg_r) < MIN_LISTS) begin
      n_eff = NW'(MIN_LISTS);
    end else if (32'(cfg_r) > MAX_LISTS) begin
      n_eff = NW'(MAX_LISTS);
    end else begin
      n_eff = NW'(cfg_r);
    end
  end

  assign slot_free = !out_valid_r || out_ch.ready;
  assign sel_idx   = LW'(in_ch.list_select);
  assign sel_ok    = 32'(in_ch.list_select) < MAX_LISTS;
  assign list_full = !sel_ok || (len_q >= CW'(LIST_DEPTH));
  assign j_inc     = NW'(j_r) + NW'(1);
  assign diff      = hi_x_r - lo_r - CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    lo_r   <= lo_nxt;
    hi_x_r <= hi_x_nxt;
    mid_r  <= mid_nxt;
    key_r  <= key_nxt;
    pend_r <= pend_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r  <= out_value_nxt;
      out_status_r <= out_status_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    lo_nxt         = lo_r;
    hi_x_nxt       = hi_x_r;
    mid_nxt        = mid_r;
    key_nxt        = key_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    in_ch.ready    = 1'b0;
    out_load       = 1'b0;
    out_value_nxt  = '0;
    out_status_nxt = STAT_OK;
    out_last_nxt   = 1'b1;
    len_cmd        = '0;
    len_idx        = '0;
    mem_we         = 1'b0;
    mem_waddr      = {sel_idx, len_q[PW-1:0]};
    mem_raddr      = '0;

    unique case (state_r)
      S_IDLE: begin
        len_idx     = sel_idx;
        in_ch.ready = slot_free;
        if (in_ch.valid && slot_free) begin
          unique case (in_ch.operation)
            OP_CLEAR: begin
              len_cmd.clr = 1'b1;
              out_load    = 1'b1;
            end
            OP_APPEND: begin
              out_load = 1'b1;
              if (list_full) begin
                out_status_nxt = STAT_FULL;
              end else begin
                mem_we      = 1'b1;
                len_cmd.inc = 1'b1;
              end
            end
            OP_RUN: begin
              i_nxt          = '0;
              pend_valid_nxt = 1'b0;
              state_nxt      = S_KEY_RD;
            end
            default: ;
          endcase
        end
      end

      S_KEY_RD: begin
        len_idx   = '0;
        mem_raddr = {LW'(0), i_r[PW-1:0]};
        if (i_r >= len_q) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_KEY_WT;
        end
      end

      S_KEY_WT: begin
        key_nxt   = mem_rdata;
        j_nxt     = LW'(1);
        state_nxt = S_SRCH_INIT;
      end

      S_SRCH_INIT: begin
        len_idx   = j_r;
        lo_nxt    = '0;
        hi_x_nxt  = len_q;
        state_nxt = S_SRCH_RD;
      end

      S_SRCH_RD: begin
        mid_nxt   = lo_r + (diff >> 1);
        mem_raddr = {j_r, mid_nxt[PW-1:0]};
        if (lo_r >= hi_x_r) begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_KEY_RD;
        end else begin
          state_nxt = S_SRCH_CMP;
        end
      end

      S_SRCH_CMP: begin
        if (mem_rdata == key_r) begin
          if (j_inc == n_eff) begin
            state_nxt = S_MATCH;
          end else begin
            j_nxt     = j_inc[LW-1:0];
            state_nxt = S_SRCH_INIT;
          end
        end else if (mem_rdata < key_r) begin
          lo_nxt    = mid_r + CW'(1);
          state_nxt = S_SRCH_RD;
        end else begin
          hi_x_nxt  = mid_r;
          state_nxt = S_SRCH_RD;
        end
      end

      S_MATCH: begin
        if (!pend_valid_r || slot_free) begin
          out_load       = pend_valid_r;
          out_value_nxt  = pend_r;
          out_status_nxt = STAT_MATCH;
          out_last_nxt   = 1'b0;
          pend_nxt       = key_r;
          pend_valid_nxt = 1'b1;
          i_nxt          = i_r + CW'(1);
          state_nxt      = S_KEY_RD;
        end
      end

      S_FINISH: begin
        if (slot_free) begin
          out_load       = 1'b1;
          out_value_nxt  = pend_valid_r ? pend_r : '0;
          out_status_nxt = pend_valid_r ? STAT_MATCH : STAT_NONE;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.match_value = out_value_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.last        = out_last_r;

  assign run_taken  = in_ch.valid && in_ch.ready && (in_ch.operation == OP_RUN);
  assign none_shown = out_valid_r && (out_status_r == STAT_NONE);

  `SLI_ASSERT_SAME(a_idle_no_pend, clk, rst_n, state_r == S_IDLE, !pend_valid_r)
  `SLI_ASSERT_SAME(a_probe_in_range, clk, rst_n, state_r == S_SRCH_CMP, lo_r < hi_x_r)
  `SLI_ASSERT_SAME(a_none_is_last, clk, rst_n, none_shown, out_last_r)
  `SLI_ASSERT_NEXT(a_run_leaves_idle, clk, rst_n, run_taken, state_r == S_KEY_RD)
endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top import sli_pkg::*;;

  localparam int NUM_LISTS      = 8;
  localparam int LIST_DEPTH     = 64;
  localparam int RANDOM_GOAL    = 35;
  localparam int DRAIN_CYCLES   = 12;
  localparam int END_CYCLES     = 50;
  localparam int WATCHDOG_LIMIT = 40000;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [VAL_W-1:0] value;
    status_t          status;
    logic             last;
  } result_word_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  sli_in_if  word_in();
  sli_out_if word_out();

  sorted_list_intersection_unit #(
    .MAX_LISTS (NUM_LISTS),
    .LIST_DEPTH(LIST_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (word_in),
    .out_ch   (word_out),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the lists and the list_count register.
  logic [VAL_W-1:0] shadow_lists [NUM_LISTS][LIST_DEPTH];
  int               shadow_len   [NUM_LISTS];
  logic [CFG_W-1:0] shadow_count;

  result_word_t awaited_words[$];

  int items_sent       = 0;
  int results_checked  = 0;
  int error_count      = 0;
  int count_writes     = 0;
  int idle_cycles      = 0;
  int hold_off_left    = 0;
  int ready_pause      = 0;
  bit no_gaps          = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic void queue_word(input logic [VAL_W-1:0] value, input status_t status,
                                     input logic last);
    result_word_t w;
    w.value  = value;
    w.status = status;
    w.last   = last;
    awaited_words.insert(awaited_words.size(), w);
  endfunction

  function automatic bit found_in(input int which, input logic [VAL_W-1:0] key);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = shadow_len[which] - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (shadow_lists[which][mid] == key) begin
        return 1'b1;
      end
      if (shadow_lists[which][mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void predict_word(input logic [OP_W-1:0] op,
                                       input logic [SEL_W-1:0] sel,
                                       input logic [VAL_W-1:0] val);
    int               lists_used;
    int               hits;
    bit               in_all;
    logic [VAL_W-1:0] key;
    logic [VAL_W-1:0] held_key;
    case (op)
      OP_CLEAR: begin
        for (int l = 0; l < NUM_LISTS; l++) begin
          shadow_len[l] = 0;
        end
        queue_word('0, STAT_OK, 1'b1);
      end
      OP_APPEND: begin
        if (shadow_len[sel] >= LIST_DEPTH) begin
          queue_word('0, STAT_FULL, 1'b1);
        end else begin
          shadow_lists[sel][shadow_len[sel]] = val;
          shadow_len[sel]++;
          queue_word('0, STAT_OK, 1'b1);
        end
      end
      OP_RUN: begin
        lists_used = shadow_count;
        if (lists_used < MIN_LISTS) begin
          lists_used = MIN_LISTS;
        end
        if (lists_used > NUM_LISTS) begin
          lists_used = NUM_LISTS;
        end
        hits = 0;
        for (int i = 0; i < shadow_len[0]; i++) begin
          key = shadow_lists[0][i];
          in_all = 1'b1;
          for (int j = 1; j < lists_used && in_all; j++) begin
            in_all = found_in(j, key);
          end
          if (in_all) begin
            // A match is held back until we know whether it is the final one.
            if (hits > 0) begin
              queue_word(held_key, STAT_MATCH, 1'b0);
            end
            held_key = key;
            hits++;
          end
        end
        if (hits == 0) begin
          queue_word('0, STAT_NONE, 1'b1);
        end else begin
          queue_word(held_key, STAT_MATCH, 1'b1);
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_word(input logic [OP_W-1:0] op, input logic [SEL_W-1:0] sel,
                           input logic [VAL_W-1:0] val);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      word_in.valid = 1'b0;
    end
    @(negedge clk);
    word_in.valid         = 1'b1;
    word_in.operation     = op;
    word_in.list_select   = sel;
    word_in.element_value = val;
    @(posedge clk);
    while (!word_in.ready) begin
      @(posedge clk);
    end
    predict_word(op, sel, val);
    if (op != OP_UNUSED) begin
      items_sent++;
    end
  endtask

  task automatic wait_drained(input int settle);
    @(negedge clk);
    word_in.valid = 1'b0;
    while (awaited_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_list_count(input logic [CFG_W-1:0] count);
    wait_drained(DRAIN_CYCLES);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = count;
    @(negedge clk);
    cfg_we       = 1'b0;
    shadow_count = count;
    count_writes++;
  endtask

  task automatic test_directed_edges();
    send_word(OP_CLEAR, 3'd0, 32'h0);
    send_word(OP_RUN, 3'd0, 32'h0);
    send_word(OP_APPEND, 3'd0, 32'h0000_0000);
    send_word(OP_APPEND, 3'd0, 32'h8000_0000);
    send_word(OP_APPEND, 3'd0, 32'hFFFF_FFFF);
    send_word(OP_APPEND, 3'd0, 32'hFFFF_FFFF);
    send_word(OP_APPEND, 3'd1, 32'h0000_0000);
    send_word(OP_APPEND, 3'd1, 32'h0000_0005);
    send_word(OP_APPEND, 3'd1, 32'h7FFF_FFFF);
    send_word(OP_APPEND, 3'd1, 32'h8000_0000);
    send_word(OP_APPEND, 3'd1, 32'hFFFF_FFFF);
    send_word(OP_RUN, 3'd0, 32'h0);
    send_word(OP_UNUSED, 3'd5, 32'hA5A5_5A5A);
    send_word(OP_APPEND, 3'd7, 32'h1234_5678);
    set_list_count(4'd3);
    send_word(OP_RUN, 3'd0, 32'h0);
    // List 2 is loaded out of order, so its search follows a fixed midpoint path.
    send_word(OP_APPEND, 3'd2, 32'hFFFF_FFFF);
    send_word(OP_APPEND, 3'd2, 32'h0000_0000);
    send_word(OP_APPEND, 3'd2, 32'h8000_0000);
    send_word(OP_RUN, 3'd0, 32'h0);
    set_list_count(4'd0);
    send_word(OP_RUN, 3'd0, 32'h0);
    set_list_count(4'd1);
    send_word(OP_RUN, 3'd0, 32'h0);
    set_list_count(4'd15);
    send_word(OP_RUN, 3'd0, 32'h0);
    send_word(OP_CLEAR, 3'd0, 32'h0);
    send_word(OP_RUN, 3'd0, 32'h0);
  endtask

  task automatic test_list_overflow();
    logic [VAL_W-1:0] base;
    set_list_count(4'd2);
    send_word(OP_CLEAR, 3'd0, 32'h0);
    base = $urandom & 32'hFFFF_FF00;
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < LIST_DEPTH; k++) begin
        send_word(OP_APPEND, SEL_W'(l), base + VAL_W'(2 * k));
      end
      send_word(OP_APPEND, SEL_W'(l), $urandom);
    end
    send_word(OP_RUN, 3'd0, 32'h0);
  endtask

  task automatic test_input_stall();
    wait_drained(DRAIN_CYCLES);
    no_gaps       = 1'b1;
    hold_off_left = 400;
    for (int i = 0; i < 30; i++) begin
      send_word(OP_APPEND, SEL_W'($urandom_range(0, NUM_LISTS - 1)), $urandom);
    end
    send_word(OP_RUN, 3'd0, 32'h0);
    wait_drained(DRAIN_CYCLES);
    no_gaps = 1'b0;
  endtask

  task automatic load_list(input int which, input logic [VAL_W-1:0] base, input int span,
                           input bit [LIST_DEPTH-1:0] shared, input int density);
    for (int v = 0; v < span; v++) begin
      if ($urandom_range(0, 99) < 4) begin
        send_word(OP_UNUSED, SEL_W'($urandom), $urandom);
      end
      if ($urandom_range(0, 99) < 3) begin
        send_word(OP_APPEND, SEL_W'($urandom_range(0, NUM_LISTS - 1)), $urandom);
      end
      if (shared[v] || $urandom_range(0, 99) < density) begin
        send_word(OP_APPEND, SEL_W'(which), base + VAL_W'(v));
        if ($urandom_range(0, 9) == 0) begin
          send_word(OP_APPEND, SEL_W'(which), base + VAL_W'(v));
        end
      end
    end
  endtask

  task automatic test_random_queries();
    int                    start_items;
    int                    lists_used;
    int                    span;
    int                    density;
    int                    pick;
    logic [CFG_W-1:0]      count;
    logic [VAL_W-1:0]      base;
    bit [LIST_DEPTH-1:0]   shared;
    start_items = items_sent;
    while (items_sent - start_items < RANDOM_GOAL) begin
      count = CFG_W'($urandom_range(0, 15));
      set_list_count(count);
      lists_used = (count < MIN_LISTS) ? MIN_LISTS : (count > NUM_LISTS) ? NUM_LISTS : count;
      no_gaps = ($urandom_range(0, 3) == 0);
      send_word(OP_CLEAR, 3'd0, 32'h0);
      span = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 16)
                                         : $urandom_range(1, 6);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        base = 32'h0;
      end else if (pick == 1) begin
        base = 32'hFFFF_FFC0;
      end else begin
        base = $urandom;
        if (base > 32'hFFFF_FFBF) begin
          base = 32'hFFFF_FFBF;
        end
      end
      for (int v = 0; v < LIST_DEPTH; v++) begin
        shared[v] = ($urandom_range(0, 99) < 40);
      end
      density = $urandom_range(15, 60);
      for (int l = 0; l < lists_used; l++) begin
        load_list(l, base, span, shared, density);
      end
      if (lists_used < NUM_LISTS && $urandom_range(0, 3) == 0) begin
        load_list(lists_used, base, span, shared, density);
      end
      send_word(OP_RUN, 3'd0, 32'h0);
      if ($urandom_range(0, 2) == 0) begin
        send_word(OP_APPEND, SEL_W'($urandom_range(0, NUM_LISTS - 1)), $urandom);
        send_word(OP_RUN, 3'd0, 32'h0);
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    word_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        word_out.ready = 1'b0;
        hold_off_left--;
      end else if (ready_pause > 0) begin
        word_out.ready = 1'b0;
        ready_pause--;
      end else begin
        word_out.ready = 1'b1;
        ready_pause    = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    result_word_t want;
    if (rst_n && word_out.valid && word_out.ready) begin
      if (awaited_words.size() == 0) begin
        $display("%0t: unexpected result word, value %h status %0d last %0b", $time,
                 word_out.match_value, word_out.status, word_out.last);
        error_count++;
      end else begin
        want = awaited_words.pop_front();
        results_checked++;
        if (word_out.match_value !== want.value) begin
          $display("%0t: match_value expected %h, actual %h", $time, want.value,
                   word_out.match_value);
          error_count++;
        end
        if (word_out.status !== want.status) begin
          $display("%0t: status expected %0d, actual %0d", $time, want.status,
                   word_out.status);
          error_count++;
        end
        if (word_out.last !== want.last) begin
          $display("%0t: last expected %0b, actual %0b", $time, want.last, word_out.last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((word_in.valid && word_in.ready) || (word_out.valid && word_out.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = CFG_RESET;
    word_in.valid         = 1'b0;
    word_in.operation     = OP_CLEAR;
    word_in.list_select   = '0;
    word_in.element_value = '0;
    shadow_count          = CFG_RESET;
    for (int l = 0; l < NUM_LISTS; l++) begin
      shadow_len[l] = 0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_edges();
    test_list_overflow();
    test_input_stall();
    test_random_queries();
    wait_drained(END_CYCLES);

    $display("Sent %0d input words and checked %0d result words over %0d list_count writes,",
             items_sent, results_checked, count_writes);
    $display("covering full lists, unsorted lists, out-of-range counts and a stalled output.");
    if (error_count == 0 && awaited_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sorted_list_intersection_unit.f @@
+incdir+hdl
hdl/sli_pkg.sv
hdl/sli_in_if.sv
hdl/sli_out_if.sv
hdl/sli_mem.sv
hdl/sli_len.sv
hdl/sorted_list_intersection_unit.sv
bench/tb_top.sv
